[hw/rtl/cmm_pkg.sv]
package cmm_pkg;

  // Field widths of the input and result words
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned CH_W     = 5;
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned ACC_W    = 40;
  localparam int unsigned MIX_W    = 24;
  localparam int unsigned CFG_IDX_W = 1;

  // Input word kinds (carried on tuser)
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_COEF   = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_INPUTS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_OUTPUTS = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_OUT_RD,
    ST_OUT_LD
  } cmm_state_e;

  // Controller to datapath
  typedef struct packed {
    logic            tbl_we;     // write coefficient table
    logic            tbl_clr;    // write zero instead of the input coefficient
    logic            mac_issue;  // start a multiply-accumulate for row/col
    logic            first_col;  // first column of a frame: start from zero
    logic            sample_ld;  // latch the incoming sample
    logic            out_ld;     // load the result register from the row read
    logic            out_last;   // result is the final row of the frame
    logic [CH_W-1:0] row;
    logic [CH_W-1:0] col;
  } cmm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic mac_busy;  // multiply-accumulate stages still hold work
    logic out_free;  // result register can take a word this cycle
  } cmm_sts_t;

endpackage

[hw/rtl/cmm_ctrl.sv]
module cmm_ctrl import cmm_pkg::*; #(
  parameter int unsigned LANES = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CNT_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 mode_i,
  input  logic [CH_W-1:0]      coef_row_i,
  input  logic [CH_W-1:0]      coef_col_i,
  output cmm_cmd_t             cmd_o,
  input  cmm_sts_t             sts_i
);

  localparam int unsigned RW    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned CLR_W = 2 * RW;

  cmm_state_e       state_q, state_d;
  logic [CH_W-1:0]  pos_q, pos_d;
  logic [CH_W-1:0]  row_q, row_d;
  logic [CLR_W-1:0] clr_q, clr_d;
  logic [CNT_W-1:0] n_in_q, n_out_q;
  logic [CNT_W-1:0] n_in_eff, n_out_eff;

  // Zero counts as one, anything above the lane count saturates
  always_comb begin
    if (n_in_q == '0) begin
      n_in_eff = CNT_W'(1);
    end else if (n_in_q > CNT_W'(LANES)) begin
      n_in_eff = CNT_W'(LANES);
    end else begin
      n_in_eff = n_in_q;
    end
    if (n_out_q == '0) begin
      n_out_eff = CNT_W'(1);
    end else if (n_out_q > CNT_W'(LANES)) begin
      n_out_eff = CNT_W'(LANES);
    end else begin
      n_out_eff = n_out_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      pos_q   <= '0;
      row_q   <= '0;
      clr_q   <= '0;
      n_in_q  <= CNT_W'(1);
      n_out_q <= CNT_W'(1);
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      row_q   <= row_d;
      clr_q   <= clr_d;
      if (cfg_we_i && cfg_idx_i == REG_NUM_INPUTS) begin
        n_in_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == REG_NUM_OUTPUTS) begin
        n_out_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    row_d      = row_q;
    clr_d      = clr_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.row  = row_q;
    cmd_o.col  = pos_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.tbl_we  = 1'b1;
        cmd_o.tbl_clr = 1'b1;
        cmd_o.row     = CH_W'(clr_q[CLR_W-1:RW]);
        cmd_o.col     = CH_W'(clr_q[RW-1:0]);
        clr_d         = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (mode_i == MODE_COEF) begin
            cmd_o.row = coef_row_i;
            cmd_o.col = coef_col_i;
            // drop writes outside the table
            cmd_o.tbl_we = (7'(coef_row_i) < 7'(LANES)) && (7'(coef_col_i) < 7'(LANES));
          end else begin
            cmd_o.sample_ld = 1'b1;
            row_d           = '0;
            state_d         = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        cmd_o.mac_issue = 1'b1;
        cmd_o.first_col = (pos_q == '0);
        row_d           = row_q + 1'b1;
        if (row_q == CH_W'(LANES - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.mac_busy) begin
          if ((CNT_W'(pos_q) + CNT_W'(1)) < n_in_eff) begin
            pos_d   = pos_q + 1'b1;
            state_d = ST_IDLE;
          end else begin
            pos_d   = '0;
            row_d   = '0;
            state_d = ST_OUT_RD;
          end
        end
      end
      ST_OUT_RD: begin
        state_d = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.out_last = (CNT_W'(row_q) + CNT_W'(1)) == n_out_eff;
          if (cmd_o.out_last) begin
            state_d = ST_IDLE;
          end else begin
            row_d   = row_q + 1'b1;
            state_d = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/cmm_datapath.sv]
module cmm_datapath import cmm_pkg::*; #(
  parameter int unsigned LANES = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmm_cmd_t                   cmd_i,
  output cmm_sts_t                   sts_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic signed [COEF_W-1:0]   coef_value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [CH_W-1:0]            out_channel_o,
  output logic signed [MIX_W-1:0]    mixed_value_o,
  output logic                       out_last_o
);

  localparam int unsigned RW      = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned TBL_AW  = 2 * RW;
  localparam int unsigned PROD_W  = SAMPLE_W + COEF_W;
  localparam int unsigned SHIFT   = 12;
  localparam int unsigned SHR_W   = ACC_W - SHIFT;

  localparam logic signed [SHR_W-1:0] SAT_HI = SHR_W'((1 << (MIX_W - 1)) - 1);
  localparam logic signed [SHR_W-1:0] SAT_LO = -SHR_W'(1 << (MIX_W - 1));

  logic signed [COEF_W-1:0] tbl_mem [2**TBL_AW];
  logic signed [ACC_W-1:0]  acc_mem [2**RW];

  logic [TBL_AW-1:0]          tbl_addr;
  logic signed [COEF_W-1:0]   coef_rd_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [ACC_W-1:0]    acc_rd_q;
  logic [RW-1:0]              acc_raddr;
  logic signed [PROD_W-1:0]   prod_q;
  logic [RW-1:0]              row1_q, row2_q;
  logic                       first1_q, first2_q;
  logic                       v1_q, v2_q;
  logic signed [ACC_W-1:0]    acc_sum;
  logic signed [SHR_W-1:0]    acc_shr;
  logic signed [MIX_W-1:0]    acc_sat;
  logic                       out_valid_q;
  logic [CH_W-1:0]            out_channel_q;
  logic signed [MIX_W-1:0]    mixed_q;
  logic                       out_last_q;

  assign tbl_addr = {cmd_i.row[RW-1:0], cmd_i.col[RW-1:0]};

  // Coefficient table: one write and one read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_we) begin
      tbl_mem[tbl_addr] <= cmd_i.tbl_clr ? '0 : coef_value_i;
    end
    coef_rd_q <= tbl_mem[tbl_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sample_ld) begin
      sample_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.mac_issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    row1_q   <= cmd_i.row[RW-1:0];
    first1_q <= cmd_i.first_col;
    row2_q   <= row1_q;
    first2_q <= first1_q;
    prod_q   <= sample_q * coef_rd_q;
  end

  // Row accumulators: read for the multiply stage, else for result readout
  assign acc_raddr = v1_q ? row1_q : cmd_i.row[RW-1:0];
  // The first column starts each row over, so no clearing is needed
  assign acc_sum   = (first2_q ? '0 : acc_rd_q) + ACC_W'(prod_q);

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      acc_mem[row2_q] <= acc_sum;
    end
    acc_rd_q <= acc_mem[acc_raddr];
  end

  // Floor shift, then clamp to the result width
  always_comb begin
    acc_shr = SHR_W'(acc_rd_q >>> SHIFT);
    if (acc_shr > SAT_HI) begin
      acc_sat = MIX_W'(SAT_HI);
    end else if (acc_shr < SAT_LO) begin
      acc_sat = MIX_W'(SAT_LO);
    end else begin
      acc_sat = MIX_W'(acc_shr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_channel_q <= cmd_i.row;
      mixed_q       <= acc_sat;
      out_last_q    <= cmd_i.out_last;
    end
  end

  assign sts_o.mac_busy = v1_q | v2_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_channel_q;
  assign mixed_value_o = mixed_q;
  assign out_last_o    = out_last_q;

endmodule

[hw/rtl/channel_matrix_mixer_unit.sv]
// Channel    Dir  Handshake               Content
// s_axis     in   tvalid/tready           sample or coefficient word, kind on tuser
// m_axis     out  tvalid/tready, tlast    one mixed word per output row
// cfg        in   cfg_we_i                num_inputs (0), num_outputs (1)
//
// A sample word runs one shared 16x16 multiplier over all LANES rows of the
// table, with a three-stage read/multiply/accumulate pipe. A coefficient word
// is written straight to the table. After the final column of a frame, each
// output row is read from its accumulator and loaded into the result register,
// which can wait on m_axis. After reset the coefficient table is cleared one
// entry per cycle, all 2**(2*ceil(log2(LANES))) entries (1024 at the default),
// with s_axis_tready low. The result word sits in its own register, so s_axis
// opens again while the last row of a frame still waits on m_axis.
module channel_matrix_mixer_unit import cmm_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CNT_W-1:0]     cfg_data_i,
  // input words
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [15:0] sample, [20:16] coef_row, [25:21] coef_col, [41:26] coef_value
  input  logic [47:0]          s_axis_tdata,
  // [0] mode
  input  logic                 s_axis_tuser,
  // result words
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [4:0] out_channel, [28:5] mixed_value
  output logic [31:0]          m_axis_tdata,
  output logic                 m_axis_tlast
);

  // Rows and columns actually held in the table
  localparam int unsigned LANES = (MAX_CHANNELS < 32) ? MAX_CHANNELS : 32;

  cmm_cmd_t                   cmd;
  cmm_sts_t                   sts;
  logic signed [SAMPLE_W-1:0] sample;
  logic [CH_W-1:0]            coef_row;
  logic [CH_W-1:0]            coef_col;
  logic signed [COEF_W-1:0]   coef_value;
  logic [CH_W-1:0]            out_channel;
  logic signed [MIX_W-1:0]    mixed_value;

  // Unpack the input word
  assign sample     = s_axis_tdata[15:0];
  assign coef_row   = s_axis_tdata[20:16];
  assign coef_col   = s_axis_tdata[25:21];
  assign coef_value = s_axis_tdata[41:26];

  // Sequencer: frame position, row walk, output readout, table clear
  cmm_ctrl #(
    .LANES (LANES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .mode_i     (s_axis_tuser),
    .coef_row_i (coef_row),
    .coef_col_i (coef_col),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Table, shared MAC, row accumulators and result register
  cmm_datapath #(
    .LANES (LANES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .sample_i      (sample),
    .coef_value_i  (coef_value),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_channel_o (out_channel),
    .mixed_value_o (mixed_value),
    .out_last_o    (m_axis_tlast)
  );

  // Pack the result word, zero-fill to whole bytes
  assign m_axis_tdata = {3'b000, mixed_value, out_channel};

endmodule
